>>> design/cnlv_pkg.sv
// Shared types and constants of the card number check pipeline.
`default_nettype none
package cnlv_pkg;
	localparam int unsigned NUM_W          = 63;
	localparam int unsigned DIGITS         = 19;
	localparam int unsigned DIGIT_W        = 4;
	localparam int unsigned BCD_W          = DIGITS * DIGIT_W;
	localparam int unsigned CONV_W         = BCD_W + NUM_W;
	localparam int unsigned CNT_W          = 5;
	localparam int unsigned TOTAL_W        = 8;
	localparam int unsigned HALF_W         = 7;
	localparam int unsigned ITER_PER_STAGE = 8;
	localparam int unsigned CONV_STAGES    = (NUM_W + ITER_PER_STAGE - 1) / ITER_PER_STAGE;
	localparam int unsigned LO_DIGITS      = 10;
	localparam int unsigned LEN_MIN        = 13;
	localparam int unsigned LEN_MAX        = 16;
	localparam int unsigned LUHN_MOD       = 10;
	localparam int unsigned TOTAL_MAX      = 171;
	localparam int unsigned DBL_LIMIT      = 10;
	localparam int unsigned DBL_FOLD       = 9;
	localparam int unsigned BCD_ADJ_MIN    = 5;
	localparam int unsigned BCD_ADJ        = 3;

	typedef logic [DIGIT_W-1:0] digit_t;

	localparam digit_t LEAD_FOUR  = 4'd4;
	localparam digit_t LEAD_FIVE  = 4'd5;
	localparam digit_t LEAD_SIX   = 4'd6;
	localparam digit_t PAIR_HIGH  = 4'd3;
	localparam digit_t PAIR_LOW   = 4'd7;

	// conversion word: decimal digits above, remaining binary bits below
	typedef logic [CONV_W-1:0] conv_t;

	typedef struct packed {
		logic               valid_res;
		logic               length_ok;
		logic               prefix_ok;
		logic               luhn_ok;
		logic [CNT_W-1:0]   digit_count;
		logic [TOTAL_W-1:0] luhn_total;
	} result_t;
endpackage
`default_nettype wire

>>> design/cnlv_card_if.sv
// Input channel carrying one card number per word.
`default_nettype none
interface cnlv_card_if;
	logic                       valid;
	logic                       ready;
	logic [cnlv_pkg::NUM_W-1:0] card_number;

	modport source (output valid, output card_number, input ready);
	modport sink (input valid, input card_number, output ready);
endinterface
`default_nettype wire

>>> design/cnlv_verdict_if.sv
// Output channel carrying one check verdict per word.
`default_nettype none
interface cnlv_verdict_if;
	logic                         valid;
	logic                         ready;
	logic                         valid_res;
	logic                         length_ok;
	logic                         prefix_ok;
	logic                         luhn_ok;
	logic [cnlv_pkg::CNT_W-1:0]   digit_count;
	logic [cnlv_pkg::TOTAL_W-1:0] luhn_total;

	modport source (output valid, output valid_res, output length_ok, output prefix_ok,
		output luhn_ok, output digit_count, output luhn_total, input ready);
	modport sink (input valid, input valid_res, input length_ok, input prefix_ok,
		input luhn_ok, input digit_count, input luhn_total, output ready);
endinterface
`default_nettype wire

>>> design/cnlv_bcd_stage.sv
// One registered stage of the binary to decimal shift-and-add-three conversion.
`default_nettype none
module cnlv_bcd_stage #(
	parameter int unsigned ITERS = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid_in,
	input  wire cnlv_pkg::conv_t word_in,
	output logic                 up_en,
	input  wire logic            down_en,
	output logic                 valid_s1,
	output cnlv_pkg::conv_t      word_s1
);
	import cnlv_pkg::*;

	conv_t step;

	always_comb begin
		step = word_in;
		for (int i = 0; i < ITERS; i++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (step[NUM_W + d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(BCD_ADJ_MIN)) begin
					step[NUM_W + d*DIGIT_W +: DIGIT_W] =
						step[NUM_W + d*DIGIT_W +: DIGIT_W] + DIGIT_W'(BCD_ADJ);
				end
			end
			step = step << 1;
		end
	end

	assign up_en = !valid_s1 || down_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (up_en && valid_in) begin
			word_s1 <= step;
		end
	end
endmodule
`default_nettype wire

>>> design/card_number_luhn_validator_unit.sv
// Top level of the card number check: decimal conversion, length, prefix and Luhn checks.
//
// Usage: card numbers enter on the card channel (valid/ready, one 63-bit
// unsigned number per word); one verdict word leaves on the verdict channel
// for every number taken, in order.
// Structure: ten register stages. Eight stages do the binary to decimal
// conversion, eight shift-and-add-three steps each (seven in the last); one
// stage counts digits and forms two halves of the Luhn sum; the output stage
// adds the halves and forms prefix and verdict.
// Throughput: one number per cycle while the receiver keeps ready high.
// Reset clears every stage valid bit; the pipeline then holds no words.
// When the receiver stalls, the output word holds and each stage holds
// only if the stage ahead of it is full, so bubbles close up; card.ready
// falls once all ten stages are full. No word is dropped or repeated.
`default_nettype none
module card_number_luhn_validator_unit (
	input wire logic       clk,
	input wire logic       arst_n,
	cnlv_card_if.sink      card,
	cnlv_verdict_if.source verdict
);
	import cnlv_pkg::*;

	logic  vld  [0:CONV_STAGES];
	conv_t word [0:CONV_STAGES];
	logic  en   [0:CONV_STAGES];

	assign vld[0]     = card.valid;
	assign word[0]    = {{BCD_W{1'b0}}, card.card_number};
	assign card.ready = en[0];

	for (genvar k = 0; k < CONV_STAGES; k++) begin : g_conv
		localparam int unsigned ITERS = (k == CONV_STAGES - 1)
			? NUM_W - (CONV_STAGES - 1) * ITER_PER_STAGE : ITER_PER_STAGE;
		cnlv_bcd_stage #(.ITERS(ITERS)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (vld[k]),
			.word_in  (word[k]),
			.up_en    (en[k]),
			.down_en  (en[k+1]),
			.valid_s1 (vld[k+1]),
			.word_s1  (word[k+1])
		);
	end

	// digit count and Luhn half sums
	logic               vld_s9;
	logic [BCD_W-1:0]   bcd_s9;
	logic [CNT_W-1:0]   cnt_s9;
	logic [HALF_W-1:0]  lo_s9;
	logic [HALF_W-1:0]  hi_s9;
	logic [CNT_W-1:0]   cnt_c;
	logic [HALF_W-1:0]  lo_c;
	logic [HALF_W-1:0]  hi_c;
	logic               en_s10;
	digit_t             dg;
	logic [DIGIT_W:0]   dbl;
	logic [DIGIT_W:0]   red;

	always_comb begin
		cnt_c = '0;
		lo_c  = '0;
		hi_c  = '0;
		dg    = '0;
		dbl   = '0;
		red   = '0;
		for (int d = 0; d < DIGITS; d++) begin
			dg = word[CONV_STAGES][NUM_W + d*DIGIT_W +: DIGIT_W];
			if (dg != '0) begin
				cnt_c = CNT_W'(d + 1);
			end
			if ((d % 2) == 0) begin
				red = {1'b0, dg};
			end else begin
				dbl = {dg, 1'b0};
				red = (dbl >= (DIGIT_W+1)'(DBL_LIMIT)) ? dbl - (DIGIT_W+1)'(DBL_FOLD) : dbl;
			end
			if (d < LO_DIGITS) begin
				lo_c = lo_c + HALF_W'(red);
			end else begin
				hi_c = hi_c + HALF_W'(red);
			end
		end
	end

	assign en[CONV_STAGES] = !vld_s9 || en_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en[CONV_STAGES]) begin
			vld_s9 <= vld[CONV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en[CONV_STAGES] && vld[CONV_STAGES]) begin
			bcd_s9 <= word[CONV_STAGES][CONV_W-1 -: BCD_W];
			cnt_s9 <= cnt_c;
			lo_s9  <= lo_c;
			hi_s9  <= hi_c;
		end
	end

	// prefix, totals and verdict
	logic               vld_s10;
	result_t            res_s10;
	result_t            res_c;
	digit_t             lead;
	digit_t             lead2;
	logic [TOTAL_W-1:0] total;
	logic               len_ok;
	logic               pre_ok;
	logic               lu_ok;

	always_comb begin
		lead  = '0;
		lead2 = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (CNT_W'(d + 1) == cnt_s9) begin
				lead = bcd_s9[d*DIGIT_W +: DIGIT_W];
			end
			if (CNT_W'(d + 2) == cnt_s9) begin
				lead2 = bcd_s9[d*DIGIT_W +: DIGIT_W];
			end
		end
		total  = TOTAL_W'(lo_s9) + TOTAL_W'(hi_s9);
		len_ok = (cnt_s9 >= CNT_W'(LEN_MIN)) && (cnt_s9 <= CNT_W'(LEN_MAX));
		pre_ok = (cnt_s9 != '0) &&
			((lead == LEAD_FOUR) || (lead == LEAD_FIVE) || (lead == LEAD_SIX) ||
			((lead == PAIR_HIGH) && (lead2 == PAIR_LOW) && (cnt_s9 >= CNT_W'(2))));
		lu_ok = 1'b0;
		for (int m = 0; m <= TOTAL_MAX / LUHN_MOD; m++) begin
			if (total == TOTAL_W'(m * LUHN_MOD)) begin
				lu_ok = 1'b1;
			end
		end
		res_c.valid_res   = len_ok && pre_ok && lu_ok;
		res_c.length_ok   = len_ok;
		res_c.prefix_ok   = pre_ok;
		res_c.luhn_ok     = lu_ok;
		res_c.digit_count = cnt_s9;
		res_c.luhn_total  = total;
	end

	assign en_s10 = !vld_s10 || verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en_s10) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10 && vld_s9) begin
			res_s10 <= res_c;
		end
	end

	assign verdict.valid       = vld_s10;
	assign verdict.valid_res   = res_s10.valid_res;
	assign verdict.length_ok   = res_s10.length_ok;
	assign verdict.prefix_ok   = res_s10.prefix_ok;
	assign verdict.luhn_ok     = res_s10.luhn_ok;
	assign verdict.digit_count = res_s10.digit_count;
	assign verdict.luhn_total  = res_s10.luhn_total;
endmodule
`default_nettype wire
